/* rtl/cbe_pkg.sv */
// Package: shared types and constants for the cubic Bezier easing block.
`timescale 1ns / 1ps
package cbe_pkg;
  localparam int IO_W = 16;
  localparam int OUT_W = 13;
  localparam int IO_FRAC = 12;

  typedef logic signed [IO_W-1:0] coord_t;

  // x-axis control points, passed down the cell chain with each item
  typedef struct packed {
    coord_t c1;
    coord_t c2;
    coord_t p3;
  } pts_t;

  localparam logic [2:0] REG_C1X = 3'd0;
  localparam logic [2:0] REG_C1Y = 3'd1;
  localparam logic [2:0] REG_C2X = 3'd2;
  localparam logic [2:0] REG_C2Y = 3'd3;
  localparam logic [2:0] REG_EX  = 3'd4;
  localparam logic [2:0] REG_EY  = 3'd5;
endpackage

/* rtl/cbe_weights.sv */
// Bernstein weights for the three non-origin points; t and 1-t, their squares and the weights are registered in turn.
`timescale 1ns / 1ps
module cbe_weights #(
  parameter int FRAC_BITS = 12
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic [FRAC_BITS:0]   t,
  output logic [FRAC_BITS+1:0] w1,
  output logic [FRAC_BITS+1:0] w2,
  output logic [FRAC_BITS:0]   w3
);
  localparam int TW = FRAC_BITS + 1;
  localparam logic [TW-1:0] ONE = TW'(1) << FRAC_BITS;

  logic [TW-1:0] t_r, s_r, tt_r, ss_r, t2_r, s2_r;
  logic [2*TW-1:0] tt_full, ss_full;
  logic [2*TW+1:0] w1_full, w2_full;
  logic [2*TW-1:0] w3_full;

  assign tt_full = t_r * t_r;
  assign ss_full = s_r * s_r;
  assign w1_full = (2*TW+2)'(t2_r) * (2*TW+2)'(ss_r) * (2*TW+2)'(3);
  assign w2_full = (2*TW+2)'(tt_r) * (2*TW+2)'(s2_r) * (2*TW+2)'(3);
  assign w3_full = tt_r * t2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      t_r  <= t;
      s_r  <= ONE - t;
      tt_r <= tt_full[FRAC_BITS +: TW];
      ss_r <= ss_full[FRAC_BITS +: TW];
      t2_r <= t_r;
      s2_r <= s_r;
      w1   <= w1_full[FRAC_BITS +: TW+1];
      w2   <= w2_full[FRAC_BITS +: TW+1];
      w3   <= w3_full[FRAC_BITS +: TW];
    end
  end
endmodule

/* rtl/cbe_cell.sv */
// One bisection cell: evaluates x at the midpoint and narrows the bracket.
`timescale 1ns / 1ps
module cbe_cell #(
  parameter int FRAC_BITS = 12
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic                     vld_in,
  input  logic [FRAC_BITS:0]       t0_in,
  input  logic [FRAC_BITS:0]       t1_in,
  input  cbe_pkg::coord_t          x_in,
  input  logic [1:0]               mode_in,
  input  cbe_pkg::pts_t            pts_in,
  output logic                     vld_out,
  output logic [FRAC_BITS:0]       t0_out,
  output logic [FRAC_BITS:0]       t1_out,
  output cbe_pkg::coord_t          x_out,
  output logic [1:0]               mode_out,
  output cbe_pkg::pts_t            pts_out
);
  import cbe_pkg::*;
  localparam int TW = FRAC_BITS + 1;
  localparam int PW = TW + 2 + IO_W;
  localparam int SW = PW + 2;
  localparam int D = 4;  // weight unit (3) + product stage (1)

  logic [TW-1:0] mid;
  logic [TW:0] wide_sum;
  logic [TW:0] w1, w2;
  logic [TW-1:0] w3;

  // item data delayed alongside the weight pipeline
  logic [D-1:0] v_d;
  logic [TW-1:0] t0_d [D], t1_d [D], m_d [D];
  coord_t x_d [D];
  logic [1:0] md_d [D];
  pts_t p_d [D];
  logic signed [PW-1:0] p1_r, p2_r, p3_r;
  logic signed [SW-1:0] sum, target;

  assign wide_sum = {1'b0, t0_in} + {1'b0, t1_in};
  assign mid = wide_sum[TW:1];

  cbe_weights #(.FRAC_BITS(FRAC_BITS)) u_w (.clk(clk), .en(en), .t(mid), .w1(w1), .w2(w2),
    .w3(w3));

  // every stage, the weight unit included, advances on the same enable
  logic [TW:0] w1_h, w2_h;
  logic [TW-1:0] w3_h;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_d <= '0;
    end else if (en) begin
      v_d <= {v_d[D-2:0], vld_in};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t0_d[0] <= t0_in; t1_d[0] <= t1_in; m_d[0] <= mid;
      x_d[0] <= x_in; md_d[0] <= mode_in; p_d[0] <= pts_in;
      for (int i = 1; i < D; i++) begin
        t0_d[i] <= t0_d[i-1]; t1_d[i] <= t1_d[i-1]; m_d[i] <= m_d[i-1];
        x_d[i] <= x_d[i-1]; md_d[i] <= md_d[i-1]; p_d[i] <= p_d[i-1];
      end
    end
  end

  assign w1_h = w1;
  assign w2_h = w2;
  assign w3_h = w3;

  always_ff @(posedge clk) begin
    if (en) begin
      p1_r <= $signed({1'b0, w1_h}) * PW'(p_d[D-2].c1);
      p2_r <= $signed({1'b0, w2_h}) * PW'(p_d[D-2].c2);
      p3_r <= $signed({2'b0, w3_h}) * PW'(p_d[D-2].p3);
    end
  end

  assign sum = SW'(p1_r) + SW'(p2_r) + SW'(p3_r);
  assign target = SW'(x_d[D-1]) <<< FRAC_BITS;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_out <= 1'b0;
    end else if (en) begin
      vld_out <= v_d[D-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_out <= x_d[D-1];
      mode_out <= md_d[D-1];
      pts_out <= p_d[D-1];
      if (sum < target) begin
        t0_out <= m_d[D-1];
        t1_out <= t1_d[D-1];
      end else begin
        t0_out <= t0_d[D-1];
        t1_out <= m_d[D-1];
      end
    end
  end
endmodule

/* rtl/cubic_bezier_easing.sv */
// Top level: cubic Bezier easing, bisection cell chain plus y evaluation.
`timescale 1ns / 1ps
// Cubic Bezier easing. Curve from (0,0) through two control points to an end
// point, all signed Q4.12 registers on the APB-style cfg_ port (byte address
// 4*i, pready always high, reads return the register).
// Input channel: in_valid/in_ready with in_progress (signed Q4.12).
// Output channel: out_valid/out_ready with out_eased_value (0..4096, unsigned Q1.12).
// Each transaction runs through ITERATIONS bisection cells (weight unit,
// product stage, compare), then a y stage (weight unit, product) and the
// output register. Throughput is one transaction per cycle unless the
// output stalls; the whole chain advances together.
// A stalled receiver freezes the chain; in_ready drops only when the output
// register is full and not being taken, so one new item is taken each cycle
// the output drains. Reset clears all valid bits and loads the register
// defaults (identity-like curve). The user must write config only while
// idle; the block itself does not enforce it.
module cubic_bezier_easing #(
  parameter int ITERATIONS = 10,
  parameter int FRAC_BITS = 12
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [15:0]            in_progress,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [12:0]                   out_eased_value,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [4:0]                    cfg_paddr,
  input  logic [31:0]                   cfg_pwdata,
  output logic [31:0]                   cfg_prdata,
  output logic                          cfg_pready
);
  import cbe_pkg::*;
  localparam int TW = FRAC_BITS + 1;
  localparam int PW = TW + 2 + IO_W;
  localparam int SW = PW + 2;
  localparam logic [TW-1:0] ONE_T = TW'(1) << FRAC_BITS;
  localparam logic [1:0] MODE_BIS  = 2'd0;
  localparam logic [1:0] MODE_ZERO = 2'd1;
  localparam logic [1:0] MODE_ONE  = 2'd2;

  coord_t c1x_r, c1y_r, c2x_r, c2y_r, ex_r, ey_r;
  logic [2:0] cfg_idx;
  assign cfg_idx = cfg_paddr[4:2];
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1x_r <= '0; c1y_r <= '0;
      c2x_r <= 16'sd4096; c2y_r <= 16'sd4096;
      ex_r <= 16'sd4096; ey_r <= 16'sd4096;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      unique case (cfg_idx)
        REG_C1X: c1x_r <= cfg_pwdata[15:0];
        REG_C1Y: c1y_r <= cfg_pwdata[15:0];
        REG_C2X: c2x_r <= cfg_pwdata[15:0];
        REG_C2Y: c2y_r <= cfg_pwdata[15:0];
        REG_EX:  ex_r  <= cfg_pwdata[15:0];
        REG_EY:  ey_r  <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_C1X: cfg_prdata = 32'(c1x_r);
      REG_C1Y: cfg_prdata = 32'(c1y_r);
      REG_C2X: cfg_prdata = 32'(c2x_r);
      REG_C2Y: cfg_prdata = 32'(c2y_r);
      REG_EX:  cfg_prdata = 32'(ex_r);
      REG_EY:  cfg_prdata = 32'(ey_r);
      default: cfg_prdata = '0;
    endcase
  end

  // chain advances unless the output register is held
  logic en;
  assign en = !out_valid || out_ready;
  assign in_ready = en;

  logic [1:0] mode_in;
  always_comb begin
    if (in_progress <= 0) mode_in = MODE_ZERO;
    else if (in_progress >= 16'sd4096) mode_in = MODE_ONE;
    else mode_in = MODE_BIS;
  end

  logic           c_v  [ITERATIONS+1];
  logic [TW-1:0]  c_t0 [ITERATIONS+1];
  logic [TW-1:0]  c_t1 [ITERATIONS+1];
  coord_t         c_x  [ITERATIONS+1];
  logic [1:0]     c_m  [ITERATIONS+1];
  pts_t           c_p  [ITERATIONS+1];

  assign c_v[0] = in_valid && in_ready;
  assign c_t0[0] = '0;
  assign c_t1[0] = ONE_T;
  assign c_x[0] = in_progress;
  assign c_m[0] = mode_in;
  assign c_p[0] = '{c1: c1x_r, c2: c2x_r, p3: ex_r};

  for (genvar g = 0; g < ITERATIONS; g++) begin : g_cell
    cbe_cell #(.FRAC_BITS(FRAC_BITS)) u_cell (
      .clk(clk), .rst_n(rst_n), .en(en),
      .vld_in(c_v[g]), .t0_in(c_t0[g]), .t1_in(c_t1[g]), .x_in(c_x[g]),
      .mode_in(c_m[g]), .pts_in(c_p[g]),
      .vld_out(c_v[g+1]), .t0_out(c_t0[g+1]), .t1_out(c_t1[g+1]),
      .x_out(c_x[g+1]), .mode_out(c_m[g+1]), .pts_out(c_p[g+1])
    );
  end

  // final t selection, then y evaluation
  logic [TW-1:0] t_fin;
  always_comb begin
    unique case (c_m[ITERATIONS])
      MODE_ZERO: t_fin = '0;
      MODE_ONE:  t_fin = ONE_T;
      default:   t_fin = c_t0[ITERATIONS];
    endcase
  end

  logic [TW:0] yw1, yw2;
  logic [TW-1:0] yw3;
  cbe_weights #(.FRAC_BITS(FRAC_BITS)) u_yw (.clk(clk), .en(en), .t(t_fin),
    .w1(yw1), .w2(yw2), .w3(yw3));

  // y stage advances with the chain on en
  logic [3:0] yv_r;
  logic signed [PW-1:0] yp1_r, yp2_r, yp3_r;
  logic signed [SW-1:0] ysum;
  logic [OUT_W-1:0] y_val;
  localparam logic signed [SW-1:0] TOP = SW'(4096) <<< FRAC_BITS;

  always_ff @(posedge clk) begin
    if (!rst_n) yv_r <= '0;
    else if (en) yv_r <= {yv_r[2:0], c_v[ITERATIONS]};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      yp1_r <= $signed({1'b0, yw1}) * PW'(c1y_r);
      yp2_r <= $signed({1'b0, yw2}) * PW'(c2y_r);
      yp3_r <= $signed({2'b0, yw3}) * PW'(ey_r);
    end
  end

  assign ysum = SW'(yp1_r) + SW'(yp2_r) + SW'(yp3_r);
  always_comb begin
    if (ysum <= 0) y_val = '0;
    else if (ysum >= TOP) y_val = OUT_W'(4096);
    else y_val = OUT_W'(ysum >>> FRAC_BITS);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else if (en) out_valid <= yv_r[3];
  end

  always_ff @(posedge clk) begin
    if (en) out_eased_value <= y_val;
  end

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_eased_value))
    else $error("result changed while stalled");
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_eased_value <= 13'd4096)
    else $error("result out of range");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output");
endmodule

/* bench/cubic_bezier_easing_tb.sv */
// Testbench for the cubic Bezier easing block: bisection predictor and scoreboard.
`timescale 1ns / 1ps
module cubic_bezier_easing_tb;
  import cbe_pkg::*;

  localparam int STEPS = 10;
  localparam int FB = 12;
  localparam int PIPE_LAT = 5 * STEPS + 6;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [15:0] in_progress = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [12:0] out_eased_value;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [4:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  cubic_bezier_easing DUT (.*);

  // local copy of the curve registers, indexed by REG_* codes
  logic signed [15:0] curve_regs [0:5];
  logic signed [15:0] progress_q [$];
  logic [12:0] eased_q [$];
  int err_count = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_off = 0;
  int hold_cnt = 0;

  initial forever #1 clk = ~clk;

  initial begin
    #40_000_000;
    $display("cubic_bezier_easing_tb: errors");
    $finish;
  end

  function automatic longint bezier_sum(longint t, longint p1, longint p2, longint p3);
    longint s, tt, ss, w1, w2, w3;
    s = (longint'(1) << FB) - t;
    tt = (t * t) >>> FB;
    ss = (s * s) >>> FB;
    w1 = (3 * t * ss) >>> FB;
    w2 = (3 * tt * s) >>> FB;
    w3 = (tt * t) >>> FB;
    return w1 * p1 + w2 * p2 + w3 * p3;
  endfunction

  function automatic logic [12:0] ease(logic signed [15:0] prog);
    longint x, t0, t1, mid, ysum, top;
    x = prog;
    t0 = 0;
    t1 = longint'(1) << FB;
    if (x <= 0) t1 = 0;
    else if (x >= 4096) t0 = t1;
    else begin
      for (int i = 0; i < STEPS; i++) begin
        mid = (t0 + t1) >>> 1;
        if (bezier_sum(mid, curve_regs[REG_C1X], curve_regs[REG_C2X],
                       curve_regs[REG_EX]) < x * (longint'(1) << FB))
          t0 = mid;
        else
          t1 = mid;
      end
    end
    ysum = bezier_sum(t0, curve_regs[REG_C1Y], curve_regs[REG_C2Y], curve_regs[REG_EY]);
    top = longint'(4096) << FB;
    if (ysum <= 0) return 13'd0;
    if (ysum >= top) return 13'd4096;
    return 13'(ysum >>> FB);
  endfunction

  // driver
  always @(posedge clk) begin
    if (in_valid && in_ready) begin
      eased_q.push_back(ease(in_progress));
    end
    if (!in_valid || in_ready) begin
      if (progress_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_progress <= progress_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (out_valid && out_ready) begin
      if (eased_q.size() == 0) begin
        $error("unexpected transaction: eased_value=%0d", out_eased_value);
        err_count++;
      end else begin
        logic [12:0] exp_val;
        exp_val = eased_q.pop_front();
        if (out_eased_value !== exp_val) begin
          $error("eased_value: expected %0d, actual %0d", exp_val, out_eased_value);
          err_count++;
        end
      end
    end
    if (hold_off > 0) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // long receiver stall, counted here
  always @(posedge clk) begin
    if (hold_off > 0) begin
      if (hold_cnt >= hold_off) begin
        hold_off <= 0;
        hold_cnt <= 0;
      end else begin
        hold_cnt <= hold_cnt + 1;
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic signed [15:0] val);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= 5'(idx) << 2;
    cfg_pwdata <= {{16{val[15]}}, val};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    curve_regs[idx] = val;
  endtask

  task automatic drain();
    while (progress_q.size() > 0 || in_valid || eased_q.size() > 0) @(posedge clk);
    repeat (PIPE_LAT + 4) @(posedge clk);
  endtask

  task automatic load_curve(logic signed [15:0] c1x, c1y, c2x, c2y, ex, ey);
    write_reg(REG_C1X, c1x);
    write_reg(REG_C1Y, c1y);
    write_reg(REG_C2X, c2x);
    write_reg(REG_C2Y, c2y);
    write_reg(REG_EX, ex);
    write_reg(REG_EY, ey);
  endtask

  function automatic logic signed [15:0] rand_progress();
    case ($urandom_range(9))
      0: return 16'($urandom);
      1: return 16'($urandom_range(8191));
      2: return 16'(4096 - 8 + $urandom_range(16));
      default: return 16'($urandom_range(4097));
    endcase
  endfunction

  initial begin
    curve_regs[REG_C1X] = 0;
    curve_regs[REG_C1Y] = 0;
    curve_regs[REG_C2X] = 4096;
    curve_regs[REG_C2Y] = 4096;
    curve_regs[REG_EX] = 4096;
    curve_regs[REG_EY] = 4096;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    recv_idle_pct = 10;

    // directed: reset curve, then field extremes and boundaries
    progress_q = '{16'sh8000, -16'sd1, 16'sd0, 16'sd1, 16'sd2048, 16'sd4095,
                   16'sd4096, 16'sd4097, 16'sh7FFF, 16'sh5555, 16'shAAAA};
    drain();
    // ease-in-out, then extreme/non-monotonic registers
    load_curve(16'sd1720, 16'sd0, 16'sd2376, 16'sd4096, 16'sd4096, 16'sd4096);
    progress_q = '{16'sd1, 16'sd1024, 16'sd2048, 16'sd3072, 16'sd4095};
    drain();
    load_curve(16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh8000);
    progress_q = '{16'sd0, 16'sd500, 16'sd2048, 16'sd4000, 16'sd4096};
    drain();
    load_curve(16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF);
    progress_q = '{16'sd300, 16'sd2048, 16'sd4095, 16'sd4096};
    drain();

    // random phases with changing curves and idling patterns
    for (int ph = 0; ph < 6; ph++) begin
      case (ph % 3)
        0: begin send_idle_pct = 15; recv_idle_pct = 49; end
        1: begin send_idle_pct = 49; recv_idle_pct = 15; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      if (ph == 5) load_curve(16'sd0, 16'sd0, 16'sd4096, 16'sd4096, 16'sd4096, 16'sd4096);
      else if (ph % 2 == 0)
        load_curve(16'($urandom_range(4096)), 16'($urandom_range(8192) - 2048),
                   16'($urandom_range(4096)), 16'($urandom_range(8192) - 2048),
                   16'sd4096, 16'($urandom_range(8192)));
      else
        load_curve(16'($urandom), 16'($urandom), 16'($urandom),
                   16'($urandom), 16'($urandom), 16'($urandom));
      for (int i = 0; i < 270; i++) progress_q.push_back(rand_progress());
      if (ph == 2) hold_off = 300;
      drain();
    end

    if (err_count == 0) $display("cubic_bezier_easing_tb: clean");
    else $display("cubic_bezier_easing_tb: errors");
    $finish;
  end
endmodule

/* filelist.f */
rtl/cbe_pkg.sv
rtl/cbe_weights.sv
rtl/cbe_cell.sv
rtl/cubic_bezier_easing.sv
bench/cubic_bezier_easing_tb.sv
